// File: rtl/core/vlma_pkg.sv
// Shared types and constants for the variable-length moving average.
// Used by the top level and by the serial divider; depends on nothing else.
package vlma_pkg;
   localparam int SAMPLE_W = 24;
   localparam int LEN_W    = 10;
   localparam int FRAC_W   = 16;
   localparam int SUM_W    = 50;
   localparam int ACC_W    = 35;
   localparam int QUO_W    = 34;
   localparam int CNT_W    = 6;
endpackage

// File: rtl/core/vlma_div.sv
// Restoring divider, one quotient bit per cycle, for the average.
// Depends on vlma_pkg for the dividend and divisor widths.
module vlma_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [vlma_pkg::QUO_W-1:0]       dividend,
   input  logic [vlma_pkg::LEN_W-1:0]       divisor,
   output logic                             done,
   output logic [vlma_pkg::QUO_W-1:0]       quotient
);
   logic [vlma_pkg::LEN_W-1:0] rem_ff, rem_in;
   logic [vlma_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [vlma_pkg::LEN_W-1:0] dvs_ff;
   logic [vlma_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       run_ff, run_in, done_ff, done_in;
   logic [vlma_pkg::LEN_W:0]   trial, diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[vlma_pkg::QUO_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = vlma_pkg::CNT_W'(vlma_pkg::QUO_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[vlma_pkg::LEN_W-1:0];
            quo_in = {quo_ff[vlma_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[vlma_pkg::LEN_W-1:0];
            quo_in = {quo_ff[vlma_pkg::QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == vlma_pkg::CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: rtl/core/variable_length_moving_average.sv
// Top level of the variable-length moving average with its history memory.
// Depends on vlma_pkg and instantiates the serial divider vlma_div.
//
// Usage: a request carries a signed 24-bit sample and a 10-bit window length on
// req_sample and req_window_len, accepted when req_valid and req_ready are both
// high. Each request yields one response on rsp_average under rsp_valid and
// rsp_ready. Lengths above DEPTH-1 are treated as DEPTH-1.
// A window length of 0 or 1 skips the division and passes the sample to rsp_average.
// An unchanged length takes one history read, two update steps and a serial
// division. A changed length rescans the newest n samples from the
// history memory, one read per cycle, and then divides.
// The history memory has a single read port, so the rescan reads one sample at a time.
// One request is worked on at a time; req_ready is high only between requests.
// After reset the history memory is cleared one entry per cycle; meanwhile no
// request is accepted. A stalled receiver holds the response in the output
// register; the next request is still accepted and its response waits until
// the output register is free.
module variable_length_moving_average #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [vlma_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [vlma_pkg::LEN_W-1:0]          req_window_len,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [vlma_pkg::SAMPLE_W-1:0] rsp_average
);
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_CAP = (DEPTH - 1 > 1023) ? 1023 : DEPTH - 1;
   localparam logic [vlma_pkg::LEN_W-1:0] LenMax = vlma_pkg::LEN_W'(LEN_CAP);
   localparam logic [AW-1:0] AddrLast = AW'(DEPTH - 1);
   localparam logic signed [52:0] SumMax = 53'sd562949953421311;
   localparam logic signed [52:0] SumMin = -53'sd562949953421312;
   localparam logic signed [vlma_pkg::QUO_W:0] AvgMax = 35'sd8388607;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SCAN, ST_UPD_READ, ST_UPD_ADD, ST_UPD_LEAK,
      ST_DIV_START, ST_DIV_WAIT, ST_OUT
   } state_type;

   logic signed [vlma_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic signed [vlma_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic                                 mem_we;
   logic [AW-1:0]                        mem_waddr, mem_raddr;
   logic signed [vlma_pkg::SAMPLE_W-1:0] mem_wdata;

   state_type                            state_ff;
   logic [AW-1:0]                        clr_addr_ff, wptr_ff, rd_addr_ff;
   logic [vlma_pkg::LEN_W-1:0]           last_len_ff, len_ff, remain_ff;
   logic signed [vlma_pkg::SAMPLE_W-1:0] x_ff;
   logic signed [vlma_pkg::SUM_W-1:0]    sum_ff;
   logic signed [vlma_pkg::ACC_W-1:0]    acc_ff;
   logic                                 pend_ff;
   logic                                 neg_ff;
   logic                                 rsp_valid_ff;
   logic signed [vlma_pkg::SAMPLE_W-1:0] rsp_average_ff, avg_ff;

   logic [vlma_pkg::LEN_W-1:0]           len_sat;
   logic [AW-1:0]                        back_addr, wptr_next, rd_addr_dec;
   logic signed [52:0]                   add_sum, s53, seven, leak_sum;
   logic signed [52:0]                   add_clamp, leak_clamp;
   logic [vlma_pkg::SUM_W-1:0]           sum_mag;
   logic                                 div_start, div_done;
   logic [vlma_pkg::QUO_W-1:0]           quotient;
   logic signed [vlma_pkg::QUO_W:0]      q_signed;
   logic signed [vlma_pkg::SAMPLE_W-1:0] q_clamp;
   logic                                 accept;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign req_ready = (state_ff == ST_IDLE);
   assign len_sat   = (req_window_len > LenMax) ? LenMax : req_window_len;
   assign wptr_next = (wptr_ff == AddrLast) ? '0 : wptr_ff + 1'b1;
   assign rd_addr_dec = (rd_addr_ff == '0) ? AddrLast : rd_addr_ff - 1'b1;
   assign back_addr = (rd_addr_ff >= AW'(len_ff)) ? rd_addr_ff - AW'(len_ff)
                                    : rd_addr_ff + (AddrLast - AW'(len_ff)) + 1'b1;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wptr_ff;
      mem_wdata = req_sample;
      mem_raddr = rd_addr_ff;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (accept) begin
         mem_we = 1'b1;
      end
      if (state_ff == ST_UPD_READ) begin
         mem_raddr = back_addr;
      end
   end

   always_comb begin
      add_sum = 53'(sum_ff) + ((53'(x_ff) - 53'(rd_data_ff)) <<< vlma_pkg::FRAC_W);
      if (add_sum > SumMax) begin
         add_clamp = SumMax;
      end else if (add_sum < SumMin) begin
         add_clamp = SumMin;
      end else begin
         add_clamp = add_sum;
      end
      s53      = 53'(sum_ff);
      seven    = (s53 <<< 3) - s53;
      leak_sum = s53 - (seven >>> vlma_pkg::FRAC_W);
      if (leak_sum > SumMax) begin
         leak_clamp = SumMax;
      end else if (leak_sum < SumMin) begin
         leak_clamp = SumMin;
      end else begin
         leak_clamp = leak_sum;
      end
      sum_mag   = sum_ff[vlma_pkg::SUM_W-1] ? vlma_pkg::SUM_W'(-sum_ff)
                                            : vlma_pkg::SUM_W'(sum_ff);
      div_start = (state_ff == ST_DIV_START);
      q_signed  = neg_ff ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
      if (q_signed > AvgMax) begin
         q_clamp = {1'b0, {(vlma_pkg::SAMPLE_W-1){1'b1}}};
      end else if (q_signed < -AvgMax - 1) begin
         q_clamp = {1'b1, {(vlma_pkg::SAMPLE_W-1){1'b0}}};
      end else begin
         q_clamp = q_signed[vlma_pkg::SAMPLE_W-1:0];
      end
   end

   vlma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag[vlma_pkg::SUM_W-1:vlma_pkg::FRAC_W]),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         wptr_ff      <= '0;
         last_len_ff  <= '0;
         sum_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == AddrLast) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  x_ff        <= req_sample;
                  len_ff      <= len_sat;
                  last_len_ff <= len_sat;
                  wptr_ff     <= wptr_next;
                  rd_addr_ff  <= wptr_ff;
                  remain_ff   <= len_sat;
                  acc_ff      <= '0;
                  pend_ff     <= 1'b0;
                  if (len_sat <= vlma_pkg::LEN_W'(1)) begin
                     sum_ff   <= vlma_pkg::SUM_W'(req_sample) <<< vlma_pkg::FRAC_W;
                     avg_ff   <= req_sample;
                     state_ff <= ST_OUT;
                  end else if (len_sat != last_len_ff) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_UPD_READ;
                  end
               end
            end
            ST_SCAN: begin
               if (pend_ff) begin
                  acc_ff <= acc_ff + vlma_pkg::ACC_W'(rd_data_ff);
               end
               if (remain_ff != '0) begin
                  remain_ff  <= remain_ff - 1'b1;
                  rd_addr_ff <= rd_addr_dec;
                  pend_ff    <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     sum_ff   <= {acc_ff[vlma_pkg::SUM_W-vlma_pkg::FRAC_W-1:0],
                                  {vlma_pkg::FRAC_W{1'b0}}};
                     state_ff <= ST_DIV_START;
                  end
               end
            end
            ST_UPD_READ: begin
               state_ff <= ST_UPD_ADD;
            end
            ST_UPD_ADD: begin
               sum_ff   <= add_clamp[vlma_pkg::SUM_W-1:0];
               state_ff <= ST_UPD_LEAK;
            end
            ST_UPD_LEAK: begin
               sum_ff   <= leak_clamp[vlma_pkg::SUM_W-1:0];
               state_ff <= ST_DIV_START;
            end
            ST_DIV_START: begin
               neg_ff   <= sum_ff[vlma_pkg::SUM_W-1];
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  avg_ff   <= q_clamp;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_average_ff <= avg_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;
endmodule

// File: sim/tb_variable_length_moving_average.sv
// Self-checking testbench for the variable-length moving average.
// Depends on vlma_pkg and the variable_length_moving_average top level.
`timescale 1ns / 1ps

module tb_variable_length_moving_average;
   localparam int DEPTH      = 1024;
   localparam int N_RANDOM   = 515;
   localparam int WDOG_LIMIT = 200000;
   localparam longint SUM_HI = (64'sd1 <<< 49) - 1;
   localparam longint SUM_LO = -(64'sd1 <<< 49);
   localparam longint RAW_HI = (64'sd1 <<< 33) - 1;
   localparam longint RAW_LO = -(64'sd1 <<< 33);
   localparam longint AVG_HI = (64'sd1 <<< (vlma_pkg::SAMPLE_W - 1)) - 1;
   localparam longint AVG_LO = -(64'sd1 <<< (vlma_pkg::SAMPLE_W - 1));

   typedef struct packed {
      logic signed [vlma_pkg::SAMPLE_W-1:0] sample;
      logic [vlma_pkg::LEN_W-1:0]           window_len;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [vlma_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic [vlma_pkg::LEN_W-1:0] req_window_len = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [vlma_pkg::SAMPLE_W-1:0] rsp_average;

   request_type pending_requests[$];
   logic signed [vlma_pkg::SAMPLE_W-1:0] expected_averages[$];

   logic signed [vlma_pkg::SAMPLE_W-1:0] model_history[DEPTH];
   int unsigned model_wr_ptr;
   longint model_sum;
   int unsigned model_last_len;

   int mismatches = 0;
   int responses = 0;
   int requests_sent = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int recv_gap = 0;
   bit stimulus_done = 1'b0;
   bit drain_hold = 1'b0;
   bit dead_wait = 1'b0;

   variable_length_moving_average #(.DEPTH(DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample(req_sample), .req_window_len(req_window_len),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_average(rsp_average)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint floor_div_65536(longint v);
      if (v >= 0) return v >>> vlma_pkg::FRAC_W;
      return -((-v + 65535) >>> vlma_pkg::FRAC_W);
   endfunction

   function automatic logic signed [vlma_pkg::SAMPLE_W-1:0] predict_average(request_type r);
      longint x, acc, old_sample, avg;
      int unsigned n, idx;
      x = longint'($signed(r.sample));
      n = r.window_len;
      if (n > DEPTH - 1) n = DEPTH - 1;
      model_history[model_wr_ptr] = r.sample;
      if (n <= 1) begin
         model_sum = x * 65536;
      end else if (n != model_last_len) begin
         acc = 0;
         for (int i = 0; i < n; i++) begin
            idx = (model_wr_ptr + DEPTH - i) % DEPTH;
            acc += longint'(model_history[idx]);
         end
         model_sum = clip(acc, RAW_LO, RAW_HI) * 65536;
      end else begin
         idx = (model_wr_ptr + DEPTH - n) % DEPTH;
         old_sample = model_history[idx];
         acc = clip(model_sum + (x - old_sample) * 65536, SUM_LO, SUM_HI);
         acc = acc - floor_div_65536(acc * 7);
         model_sum = clip(acc, SUM_LO, SUM_HI);
      end
      model_wr_ptr = (model_wr_ptr + 1) % DEPTH;
      model_last_len = n;
      if (n <= 1) avg = x;
      else avg = model_sum / (longint'(n) * 65536);
      return vlma_pkg::SAMPLE_W'(clip(avg, AVG_LO, AVG_HI));
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   function automatic int pick_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return $urandom_range(0, 1);
      if (roll < 80) return $urandom_range(2, 24);
      if (roll < 96) return $urandom_range(25, 300);
      return $urandom_range(1000, 1023);
   endfunction

   function automatic logic signed [vlma_pkg::SAMPLE_W-1:0] pick_sample();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return vlma_pkg::SAMPLE_W'(AVG_HI);
      if (roll == 1) return vlma_pkg::SAMPLE_W'(AVG_LO);
      return vlma_pkg::SAMPLE_W'($urandom);
   endfunction

   task automatic queue_request(int s, int n);
      request_type r;
      r.sample = vlma_pkg::SAMPLE_W'(s);
      r.window_len = vlma_pkg::LEN_W'(n);
      pending_requests.push_back(r);
   endtask

   initial begin
      int len;
      int run;
      for (int i = 0; i < DEPTH; i++) model_history[i] = '0;
      model_wr_ptr = 0;
      model_sum = 0;
      model_last_len = 0;
      // Directed part: pass-through, extremes, full-depth windows,
      // changed and unchanged lengths and full-scale input.
      queue_request(0, 0);
      queue_request(int'(AVG_HI), 1);
      queue_request(int'(AVG_LO), 0);
      queue_request(1000, 2);
      queue_request(-3000, 2);
      queue_request(5, 2);
      queue_request(int'(AVG_HI), 4);
      queue_request(int'(AVG_HI), 4);
      queue_request(int'(AVG_LO), 4);
      queue_request(int'(AVG_LO), 4);
      queue_request(123456, 1023);
      queue_request(-1, 1023);
      queue_request(int'(AVG_HI), 1022);
      queue_request(int'(AVG_LO), 1022);
      queue_request(-77, 3);
      queue_request(1, 3);
      for (int i = 0; i < 6; i++) queue_request(int'(AVG_HI), 700);
      queue_request(int'(AVG_LO), 512);
      queue_request(42, 1);
      queue_request('h555555, 'h2AA);
      while (pending_requests.size() < N_RANDOM + 25) begin
         len = pick_len();
         run = (len > 300) ? 2 : $urandom_range(1, 20);
         for (int k = 0; k < run; k++) begin
            if ($urandom_range(0, 19) == 0)
               queue_request(pick_sample(), $urandom_range(0, 1023));
            else queue_request(pick_sample(), len);
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_averages.push_back(predict_average(
               request_type'({req_sample, req_window_len})));
            requests_sent <= requests_sent + 1;
            req_valid <= 1'b0;
            send_gap <= pick_gap();
            if (requests_sent == 60) drain_hold <= 1'b1;
         end else if (drain_hold) begin
            if (expected_averages.size() == 0) drain_hold <= 1'b0;
         end else if (!req_valid) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (pending_requests.size() > 0) begin
               request_type r;
               r = pending_requests.pop_front();
               req_sample <= r.sample;
               req_window_len <= r.window_len;
               req_valid <= 1'b1;
            end else begin
               stimulus_done <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            logic signed [vlma_pkg::SAMPLE_W-1:0] want;
            responses <= responses + 1;
            if (expected_averages.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("Unexpected response: average %0d", rsp_average);
            end else begin
               want = expected_averages.pop_front();
               if (want !== rsp_average) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("Mismatch on response %0d: expected %0d, got %0d",
                        responses, want, rsp_average);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 9) < 3) begin
            recv_gap <= pick_gap();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("Watchdog expired with %0d responses outstanding",
            expected_averages.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      wait (stimulus_done && expected_averages.size() == 0);
      repeat (2000) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses, %0d mismatches.",
         requests_sent, responses, mismatches);
      $display("Covered pass-through, changed and unchanged lengths and full-depth windows.");
      if (mismatches == 0 && expected_averages.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
